/* rtl/length_checksum_frame_receiver_core_assert.svh */
// Assertion macros used by the frame receiver RTL.
`ifndef LENGTH_CHECKSUM_FRAME_RECEIVER_CORE_ASSERT_SVH
`define LENGTH_CHECKSUM_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LCFR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcfr assertion failed");

// Next-cycle implication, checked outside reset.
`define LCFR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcfr assertion failed");

`endif

/* rtl/lcfr_pkg.sv */
// Types and constants of the frame receiver.
package lcfr_pkg;

  localparam int MAX_PAYLOAD = 256;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'h55;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'hAA;
  localparam logic [15:0] TIMEOUT_RST       = 16'd2000;
  localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_BADSUM   = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd3;
  localparam logic [2:0] KIND_OVERSIZE = 3'd4;

  typedef enum logic [7:0] {
    PH_HUNT     = 8'b0000_0001,
    PH_SYNC2    = 8'b0000_0010,
    PH_COMMAND  = 8'b0000_0100,
    PH_LEN_HI   = 8'b0000_1000,
    PH_LEN_LO   = 8'b0001_0000,
    PH_PAYLOAD  = 8'b0010_0000,
    PH_CHECK_LO = 8'b0100_0000,
    PH_CHECK_HI = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  command;
    logic [15:0] payload_length;
    logic        last;
  } out_item_t;

endpackage

/* rtl/length_checksum_frame_receiver_core.sv */
// A result is written into the output register in the cycle after its item is accepted.
// Throughput: one item per cycle; the single output register is the only stall point,
// and an item is taken whenever that register is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): hunting for the first header, output empty,
// configuration back to header 0x55/0xAA and a timeout of 2000 ticks.
module length_checksum_frame_receiver_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lcfr_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lcfr_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [lcfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcfr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

`include "length_checksum_frame_receiver_core_assert.svh"

  logic [7:0]                 header_first_r;
  logic [7:0]                 header_second_r;
  logic [15:0]                timeout_r;

  lcfr_pkg::phase_t           phase_r, phase_nxt;
  logic [7:0]                 frame_command_r, frame_command_nxt;
  logic [15:0]                frame_length_r, frame_length_nxt;
  logic [lcfr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [15:0]                sum_r, sum_nxt;
  logic [7:0]                 check_low_r, check_low_nxt;
  logic [15:0]                elapsed_r, elapsed_nxt;

  logic                       out_valid_r;
  lcfr_pkg::out_item_t        out_item_r;

  logic                       in_fire;
  logic                       emit;
  logic [2:0]                 kind;
  logic [7:0]                 data_byte;
  logic                       last;
  logic [7:0]                 b;
  logic [15:0]                sum_add;
  logic [15:0]                elapsed_inc;
  logic [lcfr_pkg::CNT_W-1:0] count_inc;
  logic [15:0]                received_check;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign b              = in_data.rx_byte;
  assign sum_add        = sum_r + {8'd0, b};
  assign elapsed_inc    = (elapsed_r == lcfr_pkg::ELAPSED_MAX) ? elapsed_r : elapsed_r + 16'd1;
  assign count_inc      = count_r + {{(lcfr_pkg::CNT_W-1){1'b0}}, 1'b1};
  assign received_check = {b, check_low_r};

  always_comb begin
    phase_nxt         = phase_r;
    frame_command_nxt = frame_command_r;
    frame_length_nxt  = frame_length_r;
    count_nxt         = count_r;
    sum_nxt           = sum_r;
    check_low_nxt     = check_low_r;
    elapsed_nxt       = elapsed_r;
    emit              = 1'b0;
    kind              = lcfr_pkg::KIND_DATA;
    data_byte         = 8'd0;
    last              = 1'b0;

    if (in_data.mode == lcfr_pkg::MODE_TICK) begin
      if (phase_r != lcfr_pkg::PH_HUNT) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > timeout_r) begin
          phase_nxt = lcfr_pkg::PH_HUNT;
          // Before the second header byte the frame is dropped without a result.
          if (phase_r != lcfr_pkg::PH_SYNC2) begin
            emit = 1'b1;
            kind = lcfr_pkg::KIND_TIMEOUT;
            last = 1'b1;
          end
        end
      end
    end else begin
      unique case (phase_r)
        lcfr_pkg::PH_HUNT: begin
          if (b == header_first_r) begin
            phase_nxt         = lcfr_pkg::PH_SYNC2;
            frame_command_nxt = 8'd0;
            frame_length_nxt  = 16'd0;
            count_nxt         = '0;
            sum_nxt           = 16'd0;
            check_low_nxt     = 8'd0;
            elapsed_nxt       = 16'd0;
          end
        end
        lcfr_pkg::PH_SYNC2: begin
          phase_nxt = (b == header_second_r) ? lcfr_pkg::PH_COMMAND : lcfr_pkg::PH_HUNT;
        end
        lcfr_pkg::PH_COMMAND: begin
          frame_command_nxt = b;
          sum_nxt           = sum_add;
          phase_nxt         = lcfr_pkg::PH_LEN_HI;
        end
        lcfr_pkg::PH_LEN_HI: begin
          frame_length_nxt = {b, 8'd0};
          sum_nxt          = sum_add;
          phase_nxt        = lcfr_pkg::PH_LEN_LO;
        end
        lcfr_pkg::PH_LEN_LO: begin
          frame_length_nxt = {frame_length_r[15:8], b};
          sum_nxt          = sum_add;
          if ({frame_length_r[15:8], b} > 16'(lcfr_pkg::MAX_PAYLOAD)) begin
            phase_nxt = lcfr_pkg::PH_HUNT;
            emit      = 1'b1;
            kind      = lcfr_pkg::KIND_OVERSIZE;
            last      = 1'b1;
          end else if ({frame_length_r[15:8], b} == 16'd0) begin
            phase_nxt = lcfr_pkg::PH_CHECK_LO;
          end else begin
            phase_nxt = lcfr_pkg::PH_PAYLOAD;
          end
        end
        lcfr_pkg::PH_PAYLOAD: begin
          sum_nxt   = sum_add;
          count_nxt = count_inc;
          if (16'(count_inc) >= frame_length_r) begin
            phase_nxt = lcfr_pkg::PH_CHECK_LO;
          end
          emit      = 1'b1;
          kind      = lcfr_pkg::KIND_DATA;
          data_byte = b;
        end
        lcfr_pkg::PH_CHECK_LO: begin
          check_low_nxt = b;
          phase_nxt     = lcfr_pkg::PH_CHECK_HI;
        end
        lcfr_pkg::PH_CHECK_HI: begin
          phase_nxt = lcfr_pkg::PH_HUNT;
          emit      = 1'b1;
          kind      = (received_check == ~sum_r) ? lcfr_pkg::KIND_GOOD
                                                 : lcfr_pkg::KIND_BADSUM;
          last      = 1'b1;
        end
        default: begin
          phase_nxt = lcfr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= lcfr_pkg::HEADER_FIRST_RST;
      header_second_r <= lcfr_pkg::HEADER_SECOND_RST;
      timeout_r       <= lcfr_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcfr_pkg::CFG_HEADER_FIRST:  header_first_r  <= cfg_wdata[7:0];
        lcfr_pkg::CFG_HEADER_SECOND: header_second_r <= cfg_wdata[7:0];
        lcfr_pkg::CFG_TIMEOUT_TICKS: timeout_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= lcfr_pkg::PH_HUNT;
      frame_command_r <= 8'd0;
      frame_length_r  <= 16'd0;
      count_r         <= '0;
      sum_r           <= 16'd0;
      check_low_r     <= 8'd0;
      elapsed_r       <= 16'd0;
      out_valid_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r         <= phase_nxt;
      frame_command_r <= frame_command_nxt;
      frame_length_r  <= frame_length_nxt;
      count_r         <= count_nxt;
      sum_r           <= sum_nxt;
      check_low_r     <= check_low_nxt;
      elapsed_r       <= elapsed_nxt;
      out_valid_r     <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_item_r.kind           <= kind;
      out_item_r.data_byte      <= data_byte;
      out_item_r.command        <= frame_command_nxt;
      out_item_r.payload_length <= frame_length_nxt;
      out_item_r.last           <= last;
    end
  end

  // Every result other than a payload byte closes its frame.
  `LCFR_ASSERT_IMP(a_end_has_last, out_valid_r && (out_item_r.kind != lcfr_pkg::KIND_DATA), out_item_r.last)
  // The payload count never reaches the length while payload bytes are still due.
  `LCFR_ASSERT_IMP(a_count_bound, phase_r == lcfr_pkg::PH_PAYLOAD, 16'(count_r) < frame_length_r)
  // An item that ends a frame always sends the receiver back to hunting.
  `LCFR_ASSERT_NXT(a_end_to_hunt, in_fire && emit && last, phase_r == lcfr_pkg::PH_HUNT)

endmodule

/* sim/tb_length_checksum_frame_receiver_core.sv */
// Self-checking testbench for the length/checksum frame receiver core.
module tb_length_checksum_frame_receiver_core;
  import lcfr_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predicted receiver state and register copies.
  phase_t           m_phase;
  logic [7:0]       m_command;
  logic [15:0]      m_length;
  logic [CNT_W-1:0] m_count;
  logic [15:0]      m_sum;
  logic [7:0]       m_check_low;
  logic [15:0]      m_elapsed;
  logic [7:0]       set_hdr_first;
  logic [7:0]       set_hdr_second;
  logic [15:0]      set_timeout;

  out_item_t pending_results[$];
  int failures      = 0;
  int items_sent    = 0;
  int stall_cycles  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  length_checksum_frame_receiver_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic out_item_t frame_result(input logic [2:0] kind, input logic [7:0] data,
                                             input logic last);
    out_item_t r;
    r.kind           = kind;
    r.data_byte      = data;
    r.command        = m_command;
    r.payload_length = m_length;
    r.last           = last;
    return r;
  endfunction

  // Advances the predicted state by one item; returns 1 when a result is due.
  function automatic bit predict_step(input in_item_t it, output out_item_t res);
    logic [15:0] received;
    res = '0;
    if (it.mode == MODE_TICK) begin
      if (m_phase == PH_HUNT) return 1'b0;
      if (m_elapsed != ELAPSED_MAX) m_elapsed = m_elapsed + 16'd1;
      if (m_elapsed > set_timeout) begin
        // A frame still waiting for its second header is dropped silently.
        if (m_phase == PH_SYNC2) begin
          m_phase = PH_HUNT;
          return 1'b0;
        end
        m_phase = PH_HUNT;
        res = frame_result(KIND_TIMEOUT, 8'h00, 1'b1);
        return 1'b1;
      end
      return 1'b0;
    end
    case (m_phase)
      PH_HUNT: begin
        if (it.rx_byte == set_hdr_first) begin
          m_phase     = PH_SYNC2;
          m_command   = '0;
          m_length    = '0;
          m_count     = '0;
          m_sum       = '0;
          m_check_low = '0;
          m_elapsed   = '0;
        end
      end
      PH_SYNC2: m_phase = (it.rx_byte == set_hdr_second) ? PH_COMMAND : PH_HUNT;
      PH_COMMAND: begin
        m_command = it.rx_byte;
        m_sum     = m_sum + 16'(it.rx_byte);
        m_phase   = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        m_length = {it.rx_byte, 8'h00};
        m_sum    = m_sum + 16'(it.rx_byte);
        m_phase  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        m_length[7:0] = it.rx_byte;
        m_sum         = m_sum + 16'(it.rx_byte);
        if (m_length > MAX_PAYLOAD) begin
          m_phase = PH_HUNT;
          res = frame_result(KIND_OVERSIZE, 8'h00, 1'b1);
          return 1'b1;
        end
        m_phase = (m_length != 16'd0) ? PH_PAYLOAD : PH_CHECK_LO;
      end
      PH_PAYLOAD: begin
        m_sum   = m_sum + 16'(it.rx_byte);
        m_count = m_count + 1'b1;
        if (16'(m_count) >= m_length) m_phase = PH_CHECK_LO;
        res = frame_result(KIND_DATA, it.rx_byte, 1'b0);
        return 1'b1;
      end
      PH_CHECK_LO: begin
        m_check_low = it.rx_byte;
        m_phase     = PH_CHECK_HI;
      end
      default: begin
        received = {it.rx_byte, m_check_low};
        m_phase  = PH_HUNT;
        res = frame_result((received == ~m_sum) ? KIND_GOOD : KIND_BADSUM, 8'h00, 1'b1);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d data %0d", out_data.kind, out_data.data_byte);
        failures++;
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", want.kind, out_data.kind);
        compare_field("data_byte", want.data_byte, out_data.data_byte);
        compare_field("command", want.command, out_data.command);
        compare_field("payload_length", want.payload_length, out_data.payload_length);
        compare_field("last", want.last, out_data.last);
      end
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input in_item_t it);
    out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_step(it, res)) pending_results.push_back(res);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(in_item_t'{MODE_TICK, 8'($urandom_range(255))});
  endtask

  // Sends one received byte, sometimes preceded by a tick.
  task automatic send_rx(input logic [7:0] b, input int tick_pct);
    if ($urandom_range(99) < tick_pct) send_tick();
    send_item(in_item_t'{MODE_BYTE, b});
  endtask

  // A negative fill gives random payload bytes.
  task automatic send_frame(input logic [7:0] command, input logic [15:0] length,
                            input bit corrupt, input int tick_pct, input int fill);
    logic [15:0] sum;
    logic [15:0] check;
    logic [7:0]  b;
    sum = 16'(command) + 16'(length[15:8]) + 16'(length[7:0]);
    send_rx(set_hdr_first, tick_pct);
    send_rx(set_hdr_second, tick_pct);
    send_rx(command, tick_pct);
    send_rx(length[15:8], tick_pct);
    send_rx(length[7:0], tick_pct);
    if (length > MAX_PAYLOAD) return;
    for (int i = 0; i < length; i++) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      sum = sum + 16'(b);
      send_rx(b, tick_pct);
    end
    check = ~sum;
    if (corrupt) check = check ^ 16'($urandom_range(65535, 1));
    send_rx(check[7:0], tick_pct);
    send_rx(check[15:8], tick_pct);
  endtask

  // Lets every pending result drain and the block settle before a register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HEADER_FIRST:  set_hdr_first  = value[7:0];
      CFG_HEADER_SECOND: set_hdr_second = value[7:0];
      CFG_TIMEOUT_TICKS: set_timeout    = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(8));
    if (r < 85) return 16'($urandom_range(40, 9));
    if (r == 85) return 16'(MAX_PAYLOAD);
    if (r < 90) return 16'($urandom_range(MAX_PAYLOAD, 41));
    if (r < 93) return 16'hFFFF;
    return 16'($urandom_range(65535, MAX_PAYLOAD + 1));
  endfunction

  task automatic test_clean_frames();
    // Zero length goes straight from the length to the check.
    send_frame(8'h00, 16'd0, 1'b0, 0, -1);
    send_frame(8'hFF, 16'd1, 1'b0, 0, 8'hFF);
    send_frame(8'h3C, 16'd2, 1'b0, 0, 8'h00);
  endtask

  task automatic test_broken_frames();
    send_frame(8'h81, 16'd0, 1'b1, 0, -1);
    send_frame(8'hA5, 16'hFFFF, 1'b0, 0, -1);
    send_frame(8'h5A, 16'(MAX_PAYLOAD + 1), 1'b0, 0, -1);
    // The byte that breaks the sync is not taken as a new first header.
    send_rx(set_hdr_first, 0);
    send_rx(set_hdr_first, 0);
    send_rx(set_hdr_second, 0);
    send_tick();
  endtask

  task automatic test_timeouts();
    wait_idle();
    write_reg(CFG_TIMEOUT_TICKS, 16'd0);
    send_rx(set_hdr_first, 0);
    send_tick();
    send_rx(set_hdr_first, 0);
    send_rx(set_hdr_second, 0);
    send_rx(8'h42, 0);
    send_tick();
    wait_idle();
    write_reg(CFG_TIMEOUT_TICKS, 16'd3);
    send_rx(set_hdr_first, 0);
    send_rx(set_hdr_second, 0);
    send_rx(8'h17, 0);
    send_rx(8'h01, 0);
    repeat (4) send_tick();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [7:0] hf, input logic [7:0] hs,
                                     input logic [15:0] tmo, input int n_items);
    int          stop_at;
    int          pick;
    int          tick_pct;
    logic [7:0]  b;
    wait_idle();
    write_reg(CFG_HEADER_FIRST, 16'(hf));
    write_reg(CFG_HEADER_SECOND, 16'(hs));
    write_reg(CFG_TIMEOUT_TICKS, tmo);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    tick_pct = (tmo < 64) ? 4 : 10;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(8'($urandom_range(255)), random_length(), 1'b0, tick_pct, -1);
      end else if (pick < 75) begin
        send_frame(8'($urandom_range(255)), random_length(), 1'b1, tick_pct, -1);
      end else if (pick < 83) begin
        // Frame cut short after its command; ticks then age it out when that is cheap.
        send_rx(set_hdr_first, 0);
        send_rx(set_hdr_second, 0);
        send_rx(8'($urandom_range(255)), 0);
        if (set_timeout < 64) repeat (int'(set_timeout) + 1) send_tick();
      end else if (pick < 90) begin
        send_rx(set_hdr_first, 0);
        do b = 8'($urandom_range(255)); while (b == set_hdr_second);
        send_rx(b, 0);
      end else begin
        repeat ($urandom_range(4, 1))
          if ($urandom_range(1)) send_tick();
          else send_rx(8'($urandom_range(255)), 0);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    m_phase        = PH_HUNT;
    m_command      = '0;
    m_length       = '0;
    m_count        = '0;
    m_sum          = '0;
    m_check_low    = '0;
    m_elapsed      = '0;
    set_hdr_first  = HEADER_FIRST_RST;
    set_hdr_second = HEADER_SECOND_RST;
    set_timeout    = TIMEOUT_RST;
    send_idle_pct  = 19;
    recv_idle_pct  = 87;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_clean_frames();
    test_broken_frames();
    test_timeouts();
    test_random_traffic(19, 87, 8'h00, 8'hFF, 16'd12, 400);
    test_random_traffic(87, 19, 8'hFF, 8'h00, 16'd65534, 400);
    test_random_traffic(0, 0, 8'($urandom_range(255)), 8'($urandom_range(255)), 16'd1, 400);
    wait_idle();

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
